### sv/irpwd_pkg.sv
package irpwd_pkg;

  // Queue geometry and frame length.
  localparam int QUEUE_DEPTH = 16;
  localparam int FRAME_BITS  = 7;
  localparam int NUM_QUEUES  = 4;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QSEL_W = $clog2(NUM_QUEUES);
  localparam int ADDR_W = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int BCNT_W = $clog2(FRAME_BITS + 1);

  // Fixed field widths.
  localparam int FUNC_W  = 2;
  localparam int WIDTH_W = 8;
  localparam int CMD_W   = 7;
  localparam int CODE_W  = 8;
  localparam int IGN_W   = 7;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [WIDTH_W-1:0] HEADER_MIN_RST = 8'd80;
  localparam logic [WIDTH_W-1:0] ONE_THRESH_RST = 8'd50;
  localparam logic [IGN_W-1:0]   IGN_FRAME_RST  = 7'd8;
  localparam logic [IGN_W-1:0]   IGN_CLICK_RST  = 7'd100;

  // Mouse button 1 command, which sets the longer ignore window.
  localparam logic [CMD_W-1:0] CLICK_CMD = 7'h1f;

  // Depth of the queue between the decoder and the scancode queues.
  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = $clog2(MID_DEPTH);
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_MIN   = 2'd0,
    CFG_ONE_THRESH   = 2'd1,
    CFG_IGNORE_FRAME = 2'd2,
    CFG_IGNORE_CLICK = 2'd3
  } cfg_reg_e;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PULSE = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    OP_PLAIN = 2'd0,
    OP_POP   = 2'd1,
    OP_PUSH  = 2'd2
  } op_kind_e;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [WIDTH_W-1:0] pulse_width;
    logic [QSEL_W-1:0]  queue_select;
  } in_t;

  typedef struct packed {
    logic               frame_done;
    logic               pop_valid;
    logic [CODE_W-1:0]  pop_data;
    logic               command_valid;
    logic [CMD_W-1:0]   command_code;
    logic               push_dropped;
  } out_t;

  // One classified beat handed from the decoder to the queue engine.
  typedef struct packed {
    op_kind_e          kind;
    logic [QSEL_W-1:0] queue;
    logic [CODE_W-1:0] code;
    logic              frame_done;
    logic              command_valid;
    logic [CMD_W-1:0]  command_code;
  } op_t;

  typedef struct packed {
    logic              hit;
    logic [QSEL_W-1:0] queue;
    logic [CODE_W-1:0] code;
  } map_t;

  // Fixed command to scancode map.
  function automatic map_t map_cmd(logic [CMD_W-1:0] cmd);
    map_t m;
    m.hit   = 1'b1;
    m.queue = '0;
    m.code  = '0;
    case (cmd)
      7'h26: begin m.queue = 2'd1; m.code = 8'hB0; end
      7'h4E: begin m.queue = 2'd1; m.code = 8'hB1; end
      7'h0E: begin m.queue = 2'd1; m.code = 8'hB7; end
      7'h54: begin m.queue = 2'd2; m.code = 8'h82; end
      7'h06: begin m.queue = 2'd1; m.code = 8'hB6; end
      7'h46: begin m.queue = 2'd1; m.code = 8'hB5; end
      7'h17: begin m.queue = 2'd0; m.code = 8'h44; end
      7'h4F: begin m.queue = 2'd3; m.code = 8'h40; end
      7'h0F: begin m.queue = 2'd3; m.code = 8'h80; end
      7'h2F: begin m.queue = 2'd3; m.code = 8'h20; end
      7'h6F: begin m.queue = 2'd3; m.code = 8'h10; end
      7'h1F: begin m.queue = 2'd3; m.code = 8'h01; end
      default: begin m.hit = 1'b0; end
    endcase
    return m;
  endfunction

endpackage

### sv/irpwd_front.sv
module irpwd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  irpwd_pkg::in_t                 in_data_i,
  input  logic                           cfg_we_i,
  input  logic [irpwd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [irpwd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output irpwd_pkg::op_t                 op_o
);
  import irpwd_pkg::*;

  logic [WIDTH_W-1:0]    header_min_q, one_thresh_q;
  logic [IGN_W-1:0]      ign_frame_q, ign_click_q;

  logic                  in_frame_q, in_frame_d;
  logic [FRAME_BITS-1:0] shift_q, shift_d;
  logic [BCNT_W-1:0]     cnt_q, cnt_d;
  logic [IGN_W-1:0]      ign_q, ign_d;
  logic [CMD_W-1:0]      latest_q, latest_d;
  logic                  unread_q, unread_d;

  logic [IGN_W-1:0]      ign_dec;
  logic [FRAME_BITS-1:0] shift_next;
  logic [BCNT_W-1:0]     cnt_next;
  logic [CMD_W-1:0]      cmd;
  map_t                  map;
  op_t                   op;

  always_comb begin
    in_frame_d = in_frame_q;
    shift_d    = shift_q;
    cnt_d      = cnt_q;
    ign_d      = ign_q;
    latest_d   = latest_q;
    unread_d   = unread_q;
    op         = '0;
    op.kind    = OP_PLAIN;

    ign_dec    = (ign_q != '0) ? ign_q - IGN_W'(1) : ign_q;
    shift_next = FRAME_BITS'({shift_q, (in_data_i.pulse_width > one_thresh_q)});
    cnt_next   = cnt_q + BCNT_W'(1);
    cmd        = CMD_W'(shift_next);
    map        = map_cmd(cmd);

    case (func_e'(in_data_i.func))
      FUNC_PULSE: begin
        if (!in_frame_q) begin
          ign_d = ign_dec;
          if (in_data_i.pulse_width >= header_min_q && ign_dec == '0) begin
            in_frame_d = 1'b1;
          end
        end else if (cnt_next == BCNT_W'(FRAME_BITS)) begin
          in_frame_d      = 1'b0;
          shift_d         = '0;
          cnt_d           = '0;
          ign_d           = (cmd == CLICK_CMD) ? ign_click_q : ign_frame_q;
          latest_d        = cmd;
          unread_d        = 1'b1;
          op.frame_done   = 1'b1;
          op.command_code = cmd;
          if (map.hit) begin
            op.kind  = OP_PUSH;
            op.queue = map.queue;
            op.code  = map.code;
          end
        end else begin
          shift_d = shift_next;
          cnt_d   = cnt_next;
        end
      end
      FUNC_POP: begin
        op.kind  = OP_POP;
        op.queue = in_data_i.queue_select;
      end
      FUNC_READ: begin
        unread_d         = 1'b0;
        op.command_valid = unread_q;
        op.command_code  = unread_q ? latest_q : '0;
      end
      default: begin
      end
    endcase
  end

  assign op_o = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_min_q <= HEADER_MIN_RST;
      one_thresh_q <= ONE_THRESH_RST;
      ign_frame_q  <= IGN_FRAME_RST;
      ign_click_q  <= IGN_CLICK_RST;
      in_frame_q   <= 1'b0;
      shift_q      <= '0;
      cnt_q        <= '0;
      ign_q        <= '0;
      latest_q     <= '0;
      unread_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_HEADER_MIN:   header_min_q <= WIDTH_W'(cfg_data_i);
          CFG_ONE_THRESH:   one_thresh_q <= WIDTH_W'(cfg_data_i);
          CFG_IGNORE_FRAME: ign_frame_q  <= IGN_W'(cfg_data_i);
          CFG_IGNORE_CLICK: ign_click_q  <= IGN_W'(cfg_data_i);
          default: begin
          end
        endcase
      end
      if (accept_i) begin
        in_frame_q <= in_frame_d;
        shift_q    <= shift_d;
        cnt_q      <= cnt_d;
        ign_q      <= ign_d;
        latest_q   <= latest_d;
        unread_q   <= unread_d;
      end
    end
  end

endmodule

### sv/irpwd_opq.sv
module irpwd_opq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  irpwd_pkg::op_t push_op_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output irpwd_pkg::op_t head_o
);
  import irpwd_pkg::*;

  op_t                  slots_q [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_q, rd_q;
  logic [MID_CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == MID_CNT_W'(MID_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : wr_q + MID_PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : rd_q + MID_PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + MID_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - MID_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### sv/irpwd_back.sv
module irpwd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            op_avail_i,
  input  irpwd_pkg::op_t  op_i,
  output logic            op_take_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output irpwd_pkg::out_t out_data_o
);
  import irpwd_pkg::*;

  logic [CODE_W-1:0] store_q [NUM_QUEUES * QUEUE_DEPTH];
  logic [PTR_W-1:0]  rd_ptr_q [NUM_QUEUES];
  logic [PTR_W-1:0]  wr_ptr_q [NUM_QUEUES];

  logic              out_valid_q;
  logic              frame_done_q, pop_valid_q, cmd_valid_q, dropped_q;
  logic [CMD_W-1:0]  cmd_code_q;
  logic [CODE_W-1:0] rdata_q;

  logic              adv;
  logic [PTR_W-1:0]  rp, wp, wp_next;
  logic              pop_hit, push_ok, push_drop;
  logic [ADDR_W-1:0] rd_addr, wr_addr;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign adv       = op_avail_i && (!out_valid_q || !out_stall_i);
  assign op_take_o = adv;

  assign rp        = rd_ptr_q[op_i.queue];
  assign wp        = wr_ptr_q[op_i.queue];
  assign wp_next   = bump(wp);
  assign pop_hit   = (op_i.kind == OP_POP) && (rp != wp);
  assign push_drop = (op_i.kind == OP_PUSH) && (wp_next == rp);
  assign push_ok   = (op_i.kind == OP_PUSH) && (wp_next != rp);
  assign rd_addr   = ADDR_W'(ADDR_W'(op_i.queue) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(rp));
  assign wr_addr   = ADDR_W'(ADDR_W'(op_i.queue) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wp));

  always_ff @(posedge clk_i) begin
    if (adv && push_ok) begin
      store_q[wr_addr] <= op_i.code;
    end
    if (adv && pop_hit) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
      end
      out_valid_q  <= 1'b0;
      frame_done_q <= 1'b0;
      pop_valid_q  <= 1'b0;
      cmd_valid_q  <= 1'b0;
      dropped_q    <= 1'b0;
      cmd_code_q   <= '0;
    end else begin
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= op_avail_i;
      end
      if (adv) begin
        if (pop_hit) begin
          rd_ptr_q[op_i.queue] <= bump(rp);
        end
        if (push_ok) begin
          wr_ptr_q[op_i.queue] <= wp_next;
        end
        frame_done_q <= op_i.frame_done;
        pop_valid_q  <= pop_hit;
        cmd_valid_q  <= op_i.command_valid;
        cmd_code_q   <= op_i.command_code;
        dropped_q    <= push_drop;
      end
    end
  end

  assign out_valid_o              = out_valid_q;
  assign out_data_o.frame_done    = frame_done_q;
  assign out_data_o.pop_valid     = pop_valid_q;
  assign out_data_o.pop_data      = pop_valid_q ? rdata_q : '0;
  assign out_data_o.command_valid = cmd_valid_q;
  assign out_data_o.command_code  = cmd_code_q;
  assign out_data_o.push_dropped  = dropped_q;

endmodule

### sv/ir_pulse_width_decoder_queues_top.sv
// Each accepted beat is held in the op queue, then its result in the output register.
// Throughput: one beat per cycle while the op queue is not full; the output
// register and a four-entry op queue let input acceptance continue while a result
// waits on out_stall_i.
// Reset (rst_ni low, asynchronous) clears the decoder state, queue pointers and
// handshake state and loads the configuration defaults; the scancode store is
// not cleared, since equal pointers already mark every queue empty.
module ir_pulse_width_decoder_queues_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  irpwd_pkg::in_t                   in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output irpwd_pkg::out_t                  out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [irpwd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [irpwd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import irpwd_pkg::*;

  // The front end decodes pulses, owns the frame state and the latest command,
  // and turns each beat into one operation: a plain result, a queue pop, or a
  // scancode push. Its state never depends on queue occupancy, so it can run
  // ahead of the queue engine.
  logic accept;
  logic opq_full, opq_empty, op_take;
  op_t  front_op, head_op;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = opq_full;

  // Configuration registers are always writable.
  assign cfg_ready_o = 1'b1;

  irpwd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .op_o        (front_op)
  );

  // The op queue keeps beats in order, so pushes and pops reach the ring
  // queues in the same order the beats were accepted.
  irpwd_opq u_opq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (accept),
    .push_op_i (front_op),
    .full_o    (opq_full),
    .pop_i     (op_take),
    .empty_o   (opq_empty),
    .head_o    (head_op)
  );

  // The back end holds the four ring queues in one store addressed by queue
  // and pointer, detects full queues, and registers the result beat.
  irpwd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_avail_i  (!opq_empty),
    .op_i        (head_op),
    .op_take_o   (op_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // An empty pop must return a zero scancode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.pop_valid |-> out_data_o.pop_data == '0)
    else $error("pop_data nonzero without pop_valid");

  // A dropped push can only come from a completed frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.push_dropped |-> out_data_o.frame_done)
    else $error("push_dropped without frame_done");

  // A beat is one function only: never a pop, a frame and a read at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({out_data_o.frame_done, out_data_o.pop_valid,
                                out_data_o.command_valid}) <= 1)
    else $error("result beat mixes functions");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import irpwd_pkg::*;

  // A beat that stays unaccepted this long means the block has hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to let pass once the last result is in, before a register write or the verdict.
  localparam int SETTLE_CYCLES  = 6;

  // Decoder state of one frame receiver; the predictor keeps the live copy and
  // the stimulus generator keeps a shadow copy to shape well-formed frames.
  typedef struct packed {
    logic               in_frame;
    logic [CMD_W-1:0]   shift;
    logic [BCNT_W-1:0]  bits;
    logic [IGN_W-1:0]   hold_off;
  } frame_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_HEADER_MIN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ir_pulse_width_decoder_queues_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Beats waiting for the driver, and predicted results waiting for the block.
  in_t  pending_beats[$];
  out_t expected_results[$];

  int   mismatches = 0;
  int   quiet_cycles = 0;
  logic in_fire = 1'b0;
  // While calm is set, neither side inserts gaps, which gives back-to-back stretches.
  logic calm = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;

  // Predictor copy of the configuration registers, loaded with the reset values.
  logic [WIDTH_W-1:0] cfg_header_min = HEADER_MIN_RST;
  logic [WIDTH_W-1:0] cfg_one_thresh = ONE_THRESH_RST;
  logic [IGN_W-1:0]   cfg_ign_frame  = IGN_FRAME_RST;
  logic [IGN_W-1:0]   cfg_ign_click  = IGN_CLICK_RST;

  // Predictor copy of the decoder, the scancode queues and the latest command.
  frame_state_t       live_fs = '0;
  logic [CODE_W-1:0]  scancodes[NUM_QUEUES][QUEUE_DEPTH];
  int                 rd_ptr[NUM_QUEUES] = '{default: 0};
  int                 wr_ptr[NUM_QUEUES] = '{default: 0};
  logic [CMD_W-1:0]   last_cmd = '0;
  logic               cmd_unread = 1'b0;

  // Stimulus side: shadow decoder, item count and mix of the current phase.
  frame_state_t       gen_fs = '0;
  int                 phase_items = 0;
  int                 pop_pct = 0;
  int                 read_pct = 0;
  logic [CMD_W-1:0]   mapped_cmds[12] = '{7'h26, 7'h4E, 7'h0E, 7'h54, 7'h06, 7'h46,
                                          7'h17, 7'h4F, 7'h0F, 7'h2F, 7'h6F, 7'h1F};

  // Feeds one pulse width into a frame receiver. While idle, a pending hold-off
  // is counted down first and only then may a wide pulse open a frame. Inside a
  // frame, each pulse shifts in one bit, MSB first; the last bit closes the
  // frame and reloads the hold-off, with the longer value for a mouse click.
  function automatic logic step_pulse(inout frame_state_t fs,
                                      input logic [WIDTH_W-1:0] w,
                                      output logic [CMD_W-1:0] cmd);
    logic done;
    done = 1'b0;
    cmd = '0;
    if (!fs.in_frame) begin
      if (fs.hold_off != '0) fs.hold_off = fs.hold_off - 1'b1;
      if (w >= cfg_header_min && fs.hold_off == '0) fs.in_frame = 1'b1;
    end else begin
      fs.shift = {fs.shift[CMD_W-2:0], w > cfg_one_thresh};
      fs.bits = fs.bits + 1'b1;
      if (fs.bits >= FRAME_BITS) begin
        cmd = fs.shift;
        fs.hold_off = (cmd == CLICK_CMD) ? cfg_ign_click : cfg_ign_frame;
        fs.shift = '0;
        fs.bits = '0;
        fs.in_frame = 1'b0;
        done = 1'b1;
      end
    end
    return done;
  endfunction

  // Works out the result of one accepted beat and advances the predictor state.
  function automatic out_t decode_beat(input in_t beat);
    out_t              res;
    logic [CMD_W-1:0]  cmd;
    logic [CODE_W-1:0] code;
    logic              hit;
    int                q;
    int                nxt;
    res = '0;
    code = '0;
    q = beat.queue_select;
    case (func_e'(beat.func))
      FUNC_PULSE: begin
        if (step_pulse(live_fs, beat.pulse_width, cmd)) begin
          res.frame_done = 1'b1;
          res.command_code = cmd;
          last_cmd = cmd;
          cmd_unread = 1'b1;
          hit = 1'b1;
          case (cmd)
            7'h26: begin q = 1; code = 8'hB0; end
            7'h4E: begin q = 1; code = 8'hB1; end
            7'h0E: begin q = 1; code = 8'hB7; end
            7'h54: begin q = 2; code = 8'h82; end
            7'h06: begin q = 1; code = 8'hB6; end
            7'h46: begin q = 1; code = 8'hB5; end
            7'h17: begin q = 0; code = 8'h44; end
            7'h4F: begin q = 3; code = 8'h40; end
            7'h0F: begin q = 3; code = 8'h80; end
            7'h2F: begin q = 3; code = 8'h20; end
            7'h6F: begin q = 3; code = 8'h10; end
            CLICK_CMD: begin q = 3; code = 8'h01; end
            default: hit = 1'b0;
          endcase
          if (hit) begin
            // One slot always stays free so that equal pointers mean empty.
            nxt = (wr_ptr[q] + 1) % QUEUE_DEPTH;
            if (nxt == rd_ptr[q]) begin
              res.push_dropped = 1'b1;
            end else begin
              scancodes[q][wr_ptr[q]] = code;
              wr_ptr[q] = nxt;
            end
          end
        end
      end
      FUNC_POP: begin
        if (rd_ptr[q] != wr_ptr[q]) begin
          res.pop_valid = 1'b1;
          res.pop_data = scancodes[q][rd_ptr[q]];
          rd_ptr[q] = (rd_ptr[q] + 1) % QUEUE_DEPTH;
        end
      end
      FUNC_READ: begin
        // The latest command is handed out once; later reads return nothing.
        if (cmd_unread) begin
          cmd_unread = 1'b0;
          res.command_valid = 1'b1;
          res.command_code = last_cmd;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly short gaps, sometimes a few cycles, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Queues one beat for the driver. Pulse beats also advance the shadow
  // decoder so the generator always knows where the block's frame logic is.
  task automatic add_beat(input func_e f, input logic [WIDTH_W-1:0] w,
                          input logic [QSEL_W-1:0] q);
    in_t              beat;
    logic [CMD_W-1:0] unused_cmd;
    beat = '{func: f, pulse_width: w, queue_select: q};
    pending_beats.push_back(beat);
    if (f != FUNC_NOP) phase_items++;
    if (f == FUNC_PULSE) void'(step_pulse(gen_fs, w, unused_cmd));
  endtask

  // Occasionally slips a pop, a command read or an unused function code
  // between pulses. None of these disturb the frame decoder.
  task automatic side_beats();
    int r;
    logic [QSEL_W-1:0] q;
    r = $urandom_range(99);
    // Queues 1 and 3 get most of the mapped scancodes, so pop them more often.
    q = ($urandom_range(1) == 1) ? QSEL_W'($urandom_range(1) * 2 + 1) : QSEL_W'($urandom());
    if (r < pop_pct) add_beat(FUNC_POP, WIDTH_W'($urandom()), q);
    else if (r < pop_pct + read_pct) add_beat(FUNC_READ, WIDTH_W'($urandom()), QSEL_W'($urandom()));
    else if (r < pop_pct + read_pct + 3) add_beat(FUNC_NOP, WIDTH_W'($urandom()), QSEL_W'($urandom()));
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued beat is in and every predicted result has come
  // back, then lets the pipeline settle.
  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One random phase: program the registers, then mostly complete frames with
  // random content, some short bursts of stray pulses that break frames apart.
  task automatic run_phase(input int budget, input int pops, input int reads,
                           input int mapped_pct, input logic [7:0] hdr,
                           input logic [7:0] thr, input logic [7:0] frm,
                           input logic [7:0] clk);
    logic [CMD_W-1:0] cmd;
    int               thr_i;
    int               idx;
    write_reg(CFG_HEADER_MIN, hdr);
    write_reg(CFG_ONE_THRESH, thr);
    write_reg(CFG_IGNORE_FRAME, frm);
    write_reg(CFG_IGNORE_CLICK, clk);
    pop_pct = pops;
    read_pct = reads;
    phase_items = 0;
    // The block is idle here, so the predictor state is exactly the block's.
    gen_fs = live_fs;
    while (phase_items < budget) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(3, 1)) add_beat(FUNC_PULSE, WIDTH_W'($urandom()),
                                               QSEL_W'($urandom()));
      end else begin
        if ($urandom_range(99) < mapped_pct) cmd = mapped_cmds[$urandom_range(11)];
        else cmd = CMD_W'($urandom());
        // Wait out the hold-off with any widths, then send a header pulse.
        while (!gen_fs.in_frame) begin
          side_beats();
          if (gen_fs.hold_off > 1)
            add_beat(FUNC_PULSE, WIDTH_W'($urandom()), QSEL_W'($urandom()));
          else
            add_beat(FUNC_PULSE, WIDTH_W'($urandom_range(255, cfg_header_min)),
                     QSEL_W'($urandom()));
        end
        // Data bits, MSB first, picking up wherever the frame currently is.
        thr_i = cfg_one_thresh;
        while (gen_fs.in_frame) begin
          side_beats();
          idx = FRAME_BITS - 1 - int'(gen_fs.bits);
          if (cmd[idx] && thr_i < 255)
            add_beat(FUNC_PULSE, WIDTH_W'($urandom_range(255, thr_i + 1)), QSEL_W'($urandom()));
          else
            add_beat(FUNC_PULSE, WIDTH_W'($urandom_range(thr_i, 0)), QSEL_W'($urandom()));
        end
      end
    end
    wait_idle();
  endtask

  // Input driver. A beat that is not yet accepted is held unchanged; after an
  // accepted beat the driver may pause for a random number of cycles.
  always @(negedge clk_i) begin : drive_input
    logic nxt_valid;
    nxt_valid = in_valid;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        nxt_valid = 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_data <= pending_beats.pop_front();
        nxt_valid = 1'b1;
        send_gap = calm ? 0 : pick_gap();
      end else begin
        nxt_valid = 1'b0;
      end
    end
    in_valid <= nxt_valid;
  end

  // Result side back-pressure with the same mix of short and long stalls.
  always @(negedge clk_i) begin : drive_stall
    logic nxt_stall;
    if (stall_left > 0) begin
      stall_left--;
      nxt_stall = 1'b1;
    end else begin
      stall_left = calm ? 0 : pick_gap();
      nxt_stall = (stall_left > 0);
      if (nxt_stall) stall_left--;
    end
    out_stall <= nxt_stall;
  end

  // Monitor. Results are checked before the beat accepted at the same edge is
  // predicted; the op queue and output register stop a beat meeting its own result.
  always @(posedge clk_i) begin : sample
    out_t want;
    in_fire <= rst_ni && in_valid && !in_stall;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        // Narrow registers keep only their low bits.
        case (cfg_reg_e'(cfg_index))
          CFG_HEADER_MIN:   cfg_header_min = cfg_data;
          CFG_ONE_THRESH:   cfg_one_thresh = cfg_data;
          CFG_IGNORE_FRAME: cfg_ign_frame  = cfg_data[IGN_W-1:0];
          CFG_IGNORE_CLICK: cfg_ign_click  = cfg_data[IGN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, actual 0x%0h",
                   $time, out_data);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("frame_done", want.frame_done, out_data.frame_done);
          check_field("pop_valid", want.pop_valid, out_data.pop_valid);
          check_field("pop_data", want.pop_data, out_data.pop_data);
          check_field("command_valid", want.command_valid, out_data.command_valid);
          check_field("command_code", want.command_code, out_data.command_code);
          check_field("push_dropped", want.push_dropped, out_data.push_dropped);
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(decode_beat(in_data));
    end
  end

  // Watchdog on any handshake activity; also flips the no-gap mode now and then.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if ($urandom_range(149) == 0) calm <= !calm;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset configuration: empty pops and reads,
    // the unused function code, header and bit thresholds at their edges, and
    // a complete mouse click frame with its scancode and command read back.
    add_beat(FUNC_NOP, 8'hA5, 2'd2);
    add_beat(FUNC_READ, 8'h00, 2'd0);
    add_beat(FUNC_POP, 8'h00, 2'd0);
    add_beat(FUNC_POP, 8'hFF, 2'd3);
    add_beat(FUNC_PULSE, 8'd0, 2'd0);
    add_beat(FUNC_PULSE, 8'd79, 2'd1);
    add_beat(FUNC_PULSE, 8'd80, 2'd2);
    // Bits 0,0,1,1,1,1,1 give the click command; 50 is a zero, 51 a one.
    add_beat(FUNC_PULSE, 8'd0, 2'd3);
    add_beat(FUNC_PULSE, 8'd50, 2'd0);
    add_beat(FUNC_PULSE, 8'd51, 2'd1);
    add_beat(FUNC_PULSE, 8'd255, 2'd2);
    add_beat(FUNC_PULSE, 8'd51, 2'd3);
    add_beat(FUNC_PULSE, 8'd200, 2'd0);
    add_beat(FUNC_PULSE, 8'd255, 2'd1);
    // Wide pulse swallowed by the click hold-off.
    add_beat(FUNC_PULSE, 8'd255, 2'd0);
    add_beat(FUNC_READ, 8'hFF, 2'd3);
    add_beat(FUNC_READ, 8'h00, 2'd1);
    add_beat(FUNC_POP, 8'h5A, 2'd3);
    add_beat(FUNC_POP, 8'hA5, 2'd3);
    add_beat(FUNC_POP, 8'h00, 2'd1);
    add_beat(FUNC_POP, 8'hFF, 2'd2);
    add_beat(FUNC_NOP, 8'hFF, 2'd3);
    wait_idle();

    // Fill the queues with almost no pops so pushes start to be dropped; the
    // click hold-off is written with its top bit set.
    run_phase(300, 1, 8, 95, 8'd80, 8'd50, 8'd0, 8'h83);
    // Widest header and threshold: every frame decodes as command zero.
    run_phase(120, 10, 10, 60, 8'd255, 8'd255, 8'hFF, 8'd1);
    run_phase(150, 2, 10, 90, 8'd128, 8'd127, 8'd5, 8'd127);
    // Zero header and threshold with many pops to drain the queues empty.
    run_phase(180, 40, 15, 70, 8'd0, 8'd0, 8'd2, 8'd0);
    repeat (2) begin
      run_phase(80, 15, 10, 60, 8'($urandom()), 8'($urandom()),
                8'($urandom_range(15)), 8'($urandom_range(20)));
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
